/* src/pvc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared types, codes and constants of the PMBus value converter.
// ----------------------------------------------------------------------------
package pvc_pkg;

    localparam int DIV_DW = 64;
    localparam int DIV_SW = 24;

    localparam logic [19:0] MICRO_PER_UNIT = 20'd1000000;

    localparam logic [2:0] OP_L11_DEC = 3'd0;
    localparam logic [2:0] OP_L11_ENC = 3'd1;
    localparam logic [2:0] OP_L16_DEC = 3'd2;
    localparam logic [2:0] OP_L16_ENC = 3'd3;
    localparam logic [2:0] OP_DIR_DEC = 3'd4;

    localparam logic [1:0] CFG_L16_EXP  = 2'd0;
    localparam logic [1:0] CFG_DIRECT_M = 2'd1;
    localparam logic [1:0] CFG_DIRECT_B = 2'd2;
    localparam logic [1:0] CFG_DIRECT_R = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_PREPB,
        ST_SCALE,
        ST_MUL10,
        ST_DIVR_GO,
        ST_DIVR_WAIT,
        ST_SUBB,
        ST_DIVM_GO,
        ST_DIVM_WAIT,
        ST_DIVK_GO,
        ST_DIVK_WAIT,
        ST_SEARCH,
        ST_ENC,
        ST_DONE
    } pvc_state_t;

    typedef struct packed {
        logic              start;
        logic [DIV_DW-1:0] dividend;
        logic [DIV_SW-1:0] divisor;
    } pvc_div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_DW-1:0] quotient;
    } pvc_div_rsp_t;

    function automatic logic [DIV_SW-1:0] pow10(input logic [2:0] k);
        logic [DIV_SW-1:0] p;
        case (k)
            3'd1:    p = 24'd10;
            3'd2:    p = 24'd100;
            3'd3:    p = 24'd1000;
            3'd4:    p = 24'd10000;
            3'd5:    p = 24'd100000;
            3'd6:    p = 24'd1000000;
            3'd7:    p = 24'd10000000;
            default: p = 24'd1;
        endcase
        return p;
    endfunction

endpackage

/* src/pvc_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_div
// Unsigned radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pvc_div
    import pvc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  pvc_div_req_t req,
    output pvc_div_rsp_t rsp
);

    logic [DIV_SW-1:0] rem_reg, rem_next;
    logic [DIV_DW-1:0] quo_reg, quo_next;
    logic [DIV_SW-1:0] dsr_reg, dsr_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [DIV_SW:0]   trial;
    logic [DIV_SW:0]   diff;
    logic              ge;

    assign trial = {rem_reg, quo_reg[DIV_DW-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            quo_next = req.dividend;
            dsr_next = req.divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[DIV_SW-1:0] : trial[DIV_SW-1:0];
            quo_next = {quo_reg[DIV_DW-2:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

/* src/pvc_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_core
// Sequencer and working registers; drives the shared divider and shifter.
// ----------------------------------------------------------------------------
module pvc_core
    import pvc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [2:0]         operation,
    input  logic [15:0]        word_in,
    input  logic signed [31:0] micro_in,
    input  logic signed [4:0]  l16_exp,
    input  logic signed [15:0] direct_m,
    input  logic signed [15:0] direct_b,
    input  logic signed [3:0]  direct_r,
    input  pvc_div_rsp_t       div_rsp,
    output pvc_div_req_t       div_req,
    output logic               busy,
    output logic               done,
    output logic [15:0]        word_out,
    output logic signed [31:0] micro_out,
    output logic               invalid
);

    pvc_state_t         state_reg, state_next;
    logic [2:0]         op_reg, op_next;
    logic [15:0]        word_reg, word_next;
    logic signed [31:0] micro_reg, micro_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] bprod_reg, bprod_next;
    logic [3:0]         cnt_reg, cnt_next;
    logic signed [4:0]  n_reg, n_next;
    logic               neg_reg, neg_next;
    logic [15:0]        rw_reg, rw_next;
    logic signed [31:0] rm_reg, rm_next;
    logic               ri_reg, ri_next;

    logic signed [16:0] mul_a;
    logic signed [37:0] mul_p;
    logic signed [4:0]  e_sel;
    logic [4:0]         e_amt;
    logic signed [63:0] sh_val;
    logic               sh_ovf;
    logic [4:0]         l16_amt;
    logic [47:0]        l16_v;
    logic [31:0]        micro_mag;
    logic [63:0]        acc_mag;
    logic [15:0]        m_mag;
    logic [63:0]        q_sgn;
    logic               q_ovf;
    logic [4:0]         srch_amt;
    logic [27:0]        srch_out;
    logic               fits;
    logic [10:0]        y_mag;
    logic [10:0]        y_val;

    // shared multiplier by one million
    assign mul_a = (state_reg == ST_PREPB) ? 17'(direct_b)
                 : (op_reg == OP_L11_DEC)  ? 17'(signed'(word_reg[10:0]))
                 : (op_reg == OP_L16_DEC)  ? signed'({1'b0, word_reg})
                 : 17'(signed'(word_reg));
    assign mul_p = mul_a * signed'({1'b0, MICRO_PER_UNIT});

    // linear scaling by a power of two
    assign e_sel  = (op_reg == OP_L11_DEC) ? signed'(word_reg[15:11]) : l16_exp;
    assign e_amt  = 5'(-e_sel);
    assign sh_val = (e_sel >= 0) ? (acc_reg <<< e_sel[3:0]) : (acc_reg >>> e_amt);
    assign sh_ovf = (sh_val > 64'sd2147483647) || (sh_val < -64'sd2147483648);

    assign l16_amt   = (l16_exp < 0) ? 5'(-l16_exp) : 5'(l16_exp);
    assign l16_v     = (l16_exp < 0) ? ({17'd0, micro_reg[30:0]} << l16_amt)
                                     : {17'd0, micro_reg[30:0] >> l16_amt};
    assign micro_mag = micro_reg[31] ? (~micro_reg + 32'd1) : micro_reg;
    assign acc_mag   = acc_reg[63] ? (64'd0 - acc_reg) : acc_reg;
    assign m_mag     = direct_m[15] ? (16'd0 - direct_m) : direct_m;

    assign q_sgn = neg_reg ? (64'd0 - div_rsp.quotient) : div_rsp.quotient;
    assign q_ovf = neg_reg ? (div_rsp.quotient > 64'd2147483648)
                           : (div_rsp.quotient > 64'd2147483647);

    // shared shifter for the exponent search
    assign srch_amt = (state_reg == ST_ENC) ? (5'(n_reg) + 5'd16) : (5'(n_reg) + 5'd15);
    assign srch_out = acc_reg[27:0] >> srch_amt;
    assign fits     = neg_reg ? (srch_out <= 28'd1024) : (srch_out <= 28'd1023);
    assign y_mag    = neg_reg ? ((srch_out > 28'd1024) ? 11'd1024 : srch_out[10:0])
                              : ((srch_out > 28'd1023) ? 11'd1023 : srch_out[10:0]);
    assign y_val    = neg_reg ? (11'd0 - y_mag) : y_mag;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                case (op_reg)
                    OP_L11_DEC, OP_L16_DEC: state_next = ST_SCALE;
                    OP_L11_ENC: state_next = (micro_reg == 0) ? ST_DONE : ST_DIVK_GO;
                    OP_L16_ENC: state_next = (micro_reg <= 0) ? ST_DONE : ST_DIVK_GO;
                    OP_DIR_DEC: state_next = (direct_m == 0) ? ST_DONE : ST_PREPB;
                    default:    state_next = ST_DONE;
                endcase
            end
            ST_PREPB:
            begin
                if (direct_r < 0)
                    state_next = ST_MUL10;
                else if (direct_r > 0)
                    state_next = ST_DIVR_GO;
                else
                    state_next = ST_SUBB;
            end
            ST_SCALE:     state_next = ST_DONE;
            ST_MUL10:
            begin
                if (cnt_reg == 4'd1)
                    state_next = ST_SUBB;
            end
            ST_DIVR_GO:   state_next = ST_DIVR_WAIT;
            ST_DIVR_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_SUBB;
            end
            ST_SUBB:      state_next = ST_DIVM_GO;
            ST_DIVM_GO:   state_next = ST_DIVM_WAIT;
            ST_DIVM_WAIT:
            begin
                if (div_rsp.done)
                    state_next = ST_DONE;
            end
            ST_DIVK_GO:   state_next = ST_DIVK_WAIT;
            ST_DIVK_WAIT:
            begin
                if (div_rsp.done)
                    state_next = (op_reg == OP_L11_ENC) ? ST_SEARCH : ST_DONE;
            end
            ST_SEARCH:
            begin
                if ((n_reg == -5'sd16) || !fits)
                    state_next = ST_ENC;
            end
            ST_ENC:       state_next = ST_DONE;
            ST_DONE:      state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        busy             = (state_reg != ST_IDLE);
        done             = (state_reg == ST_DONE);
        div_req.start    = 1'b0;
        div_req.dividend = acc_mag;
        div_req.divisor  = 24'(MICRO_PER_UNIT);
        case (state_reg)
            ST_DIVR_GO:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = pow10(direct_r[2:0]);
            end
            ST_DIVM_GO:
            begin
                div_req.start   = 1'b1;
                div_req.divisor = {8'd0, m_mag};
            end
            ST_DIVK_GO:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = acc_reg;
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    // working registers
    always_comb
    begin
        op_next    = op_reg;
        word_next  = word_reg;
        micro_next = micro_reg;
        acc_next   = acc_reg;
        bprod_next = bprod_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        neg_next   = neg_reg;
        rw_next    = rw_reg;
        rm_next    = rm_reg;
        ri_next    = ri_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    word_next  = word_in;
                    micro_next = micro_in;
                end
            end
            ST_PREP:
            begin
                rw_next = '0;
                rm_next = '0;
                ri_next = 1'b0;
                case (op_reg)
                    OP_L11_DEC, OP_L16_DEC:
                    begin
                        acc_next = 64'(mul_p);
                    end
                    OP_L11_ENC:
                    begin
                        acc_next = signed'({16'd0, micro_mag, 16'd0});
                        neg_next = micro_reg[31];
                    end
                    OP_L16_ENC:
                    begin
                        acc_next = signed'({16'd0, l16_v});
                    end
                    OP_DIR_DEC:
                    begin
                        acc_next = 64'(mul_p);
                        ri_next  = (direct_m == 0);
                    end
                    default:
                    begin
                        ri_next = 1'b1;
                    end
                endcase
            end
            ST_PREPB:
            begin
                bprod_next = 64'(mul_p);
                cnt_next   = 4'(-direct_r);
            end
            ST_SCALE:
            begin
                rm_next = sh_ovf ? 32'sd0 : sh_val[31:0];
                ri_next = sh_ovf;
            end
            ST_MUL10:
            begin
                acc_next = (acc_reg <<< 3) + (acc_reg <<< 1);
                cnt_next = cnt_reg - 4'd1;
            end
            ST_DIVR_GO:
            begin
                neg_next = acc_reg[63];
            end
            ST_DIVR_WAIT:
            begin
                if (div_rsp.done)
                    acc_next = signed'(q_sgn);
            end
            ST_SUBB:
            begin
                acc_next = acc_reg - bprod_reg;
            end
            ST_DIVM_GO:
            begin
                neg_next = acc_reg[63] ^ direct_m[15];
            end
            ST_DIVM_WAIT:
            begin
                if (div_rsp.done)
                begin
                    rm_next = q_ovf ? 32'sd0 : signed'(q_sgn[31:0]);
                    ri_next = q_ovf;
                end
            end
            ST_DIVK_WAIT:
            begin
                if (div_rsp.done)
                begin
                    acc_next = signed'(div_rsp.quotient);
                    n_next   = 5'sd15;
                    if (div_rsp.quotient > 64'd65535)
                        rw_next = 16'hFFFF;
                    else
                        rw_next = div_rsp.quotient[15:0];
                end
            end
            ST_SEARCH:
            begin
                if ((n_reg != -5'sd16) && fits)
                    n_next = n_reg - 5'sd1;
            end
            ST_ENC:
            begin
                rw_next = {n_reg, y_val};
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        word_reg  <= word_next;
        micro_reg <= micro_next;
        acc_reg   <= acc_next;
        bprod_reg <= bprod_next;
        cnt_reg   <= cnt_next;
        n_reg     <= n_next;
        neg_reg   <= neg_next;
        rw_reg    <= rw_next;
        rm_reg    <= rm_next;
        ri_reg    <= ri_next;
    end

    assign word_out  = rw_reg;
    assign micro_out = rm_reg;
    assign invalid   = ri_reg;

endmodule

/* src/pmbus_value_converter_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmbus_value_converter_top
// Converts PMBus LINEAR11, LINEAR16 and DIRECT words to and from micro-units.
// ----------------------------------------------------------------------------
// A conversion is taken when start is high while busy is low; busy then stays
// high until the result beat, which sits on word_out, micro_out and invalid
// for the single cycle in which done is high and cannot be held off. Unknown
// codes, DIRECT with m zero, a zero LINEAR11 encode and a non-positive
// LINEAR16 encode go from ST_PREP straight to ST_DONE; LINEAR decodes pass
// through ST_SCALE first. The other paths wait on the shared radix-2 divider:
// one division for encodes and for DIRECT with R zero or negative, two for
// DIRECT with positive R. LINEAR11 encodes then run the exponent search and
// pack the word in ST_ENC, and negative R adds up to 8 multiply-by-ten steps.
// ----------------------------------------------------------------------------
module pmbus_value_converter_top
    import pvc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    output logic               done,
    input  logic [2:0]         operation,
    input  logic [15:0]        word_in,
    input  logic signed [31:0] micro_in,
    output logic [15:0]        word_out,
    output logic signed [31:0] micro_out,
    output logic               invalid,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    logic signed [4:0]  l16_exp_reg;
    logic signed [15:0] m_reg;
    logic signed [15:0] b_reg;
    logic signed [3:0]  r_reg;
    pvc_div_req_t       div_req;
    pvc_div_rsp_t       div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l16_exp_reg <= 5'sd0;
            m_reg       <= 16'sd1;
            b_reg       <= 16'sd0;
            r_reg       <= 4'sd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_L16_EXP:  l16_exp_reg <= signed'(cfg_data[4:0]);
                CFG_DIRECT_M: m_reg       <= signed'(cfg_data);
                CFG_DIRECT_B: b_reg       <= signed'(cfg_data);
                CFG_DIRECT_R: r_reg       <= signed'(cfg_data[3:0]);
                default:      r_reg       <= r_reg;
            endcase
        end
    end

    pvc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .word_in   (word_in),
        .micro_in  (micro_in),
        .l16_exp   (l16_exp_reg),
        .direct_m  (m_reg),
        .direct_b  (b_reg),
        .direct_r  (r_reg),
        .div_rsp   (div_rsp),
        .div_req   (div_req),
        .busy      (busy),
        .done      (done),
        .word_out  (word_out),
        .micro_out (micro_out),
        .invalid   (invalid)
    );

    pvc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

/* src/pvc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvc_checker
// Port-level checks of the converter's command handshake and result beat.
// ----------------------------------------------------------------------------
module pvc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] micro_out,
    input logic        invalid
);

    // a result beat only comes out of a conversion in flight
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result beat while not busy");

    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");

    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result beat longer than one cycle");

    // busy only drops right after a result beat
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> $past(done))
        else $error("busy dropped without a result beat");

    assert property (@(posedge clk) disable iff (!rst_n) (done && invalid) |-> (micro_out == 32'd0))
        else $error("invalid result with nonzero value");

endmodule

bind pmbus_value_converter_top pvc_checker u_pvc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .micro_out (micro_out),
    .invalid   (invalid)
);
